FILE: hdl/olps_pkg.sv
`timescale 1ns / 1ps
package olps_pkg;
	localparam int CAPACITY = 16;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam cnt_t CAP_CNT = CNT_W'(CAPACITY);

	localparam logic [3:0] K_PUSH_BACK  = 4'd0;
	localparam logic [3:0] K_PUSH_FRONT = 4'd1;
	localparam logic [3:0] K_INSERT     = 4'd2;
	localparam logic [3:0] K_POP_BACK   = 4'd3;
	localparam logic [3:0] K_POP_FRONT  = 4'd4;
	localparam logic [3:0] K_REMOVE     = 4'd5;
	localparam logic [3:0] K_READ_FWD   = 4'd6;
	localparam logic [3:0] K_READ_BWD   = 4'd7;
	localparam logic [3:0] K_FIND_MIN   = 4'd8;
	localparam logic [3:0] K_CLEAR      = 4'd9;
	localparam logic [3:0] K_QUERY      = 4'd10;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [3:0]         kind;
		logic signed [31:0] value;
		logic [7:0]         position;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] item_value;
		logic [6:0]         item_position;
		logic [6:0]         entry_count;
		logic               list_empty;
		logic               last;
	} res_t;
endpackage

FILE: hdl/olps_store.sv
`timescale 1ns / 1ps
module olps_store (
	input  logic                clk,
	input  logic                we,
	input  olps_pkg::idx_t      waddr,
	input  logic signed [31:0]  wdata,
	input  olps_pkg::idx_t      raddr,
	output logic signed [31:0]  rdata
);
	logic signed [31:0] mem [olps_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/ordered_list_positional_store.sv
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed words in a one-port-read memory, driven
// by a small sequencer around one read/compare/write path. Pop from the back,
// remove of the last entry, clear, query and every rejected request answer on
// the cycle after the word is taken without raising busy. Push at the back (or
// an insert at the end, or into an empty list) keeps busy high for one cycle.
// Insert and remove shift one entry at a time, a memory read, then a write
// (S_SH_RD, S_SH_WR), before the new word is written or the count drops (a pop
// from the front of a one-entry list still takes one shift step). Read-outs
// give one result per entry, each after its own memory read, and find-min reads
// and compares every entry, then answers with the first smallest one.
// Results appear for one cycle on strobe and cannot be held off by the receiver.
module ordered_list_positional_store (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  olps_pkg::cmd_t   cmd,
	output logic             busy,
	output logic             strobe,
	output olps_pkg::res_t   result
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SH_RD  = 3'd1;
	localparam logic [2:0] S_SH_WR  = 3'd2;
	localparam logic [2:0] S_INS_WR = 3'd3;
	localparam logic [2:0] S_RO_RD  = 3'd4;
	localparam logic [2:0] S_RO_EM  = 3'd5;
	localparam logic [2:0] S_MIN_RD = 3'd6;
	localparam logic [2:0] S_MIN_CM = 3'd7;

	logic [2:0]         state_q;
	olps_pkg::cnt_t     total_q, ptr_q, slot_q, best_q;
	logic               ins_q, fwd_q;
	logic signed [31:0] value_q, best_val_q;

	logic               we;
	olps_pkg::idx_t     waddr, raddr;
	logic signed [31:0] wdata, rdata;
	olps_pkg::cnt_t     ro_slot, total_dec, total_inc;
	logic [8:0]         pos9, tot9;

	olps_store u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign busy = state_q != S_IDLE;
	assign pos9 = 9'(cmd.position);
	assign tot9 = 9'(total_q);
	assign total_dec = total_q - olps_pkg::CNT_W'(1);
	assign total_inc = total_q + olps_pkg::CNT_W'(1);
	assign ro_slot = fwd_q ? ptr_q : olps_pkg::CNT_W'(total_dec - ptr_q);

	always_comb begin
		we = 1'b0;
		waddr = ptr_q[olps_pkg::IDX_W-1:0];
		wdata = rdata;
		raddr = ptr_q[olps_pkg::IDX_W-1:0];
		unique case (state_q)
			S_SH_RD: begin
				raddr = ins_q ? olps_pkg::IDX_W'(ptr_q - olps_pkg::CNT_W'(1))
				              : olps_pkg::IDX_W'(ptr_q + olps_pkg::CNT_W'(1));
			end
			S_SH_WR: we = 1'b1;
			S_INS_WR: begin
				we = 1'b1;
				waddr = slot_q[olps_pkg::IDX_W-1:0];
				wdata = value_q;
			end
			S_RO_RD: raddr = ro_slot[olps_pkg::IDX_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			total_q    <= '0;
			strobe     <= 1'b0;
			result     <= '0;
			ptr_q      <= '0;
			slot_q     <= '0;
			best_q     <= '0;
			ins_q      <= 1'b0;
			fwd_q      <= 1'b0;
			value_q    <= '0;
			best_val_q <= '0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					priority if (cmd.kind == olps_pkg::K_PUSH_BACK ||
					             cmd.kind == olps_pkg::K_PUSH_FRONT ||
					             cmd.kind == olps_pkg::K_INSERT) begin
						if (cmd.kind == olps_pkg::K_INSERT &&
						    (pos9 == 9'd0 || pos9 > tot9 + 9'd1)) begin
							strobe <= 1'b1;
							result <= '{olps_pkg::ST_BADPOS, '0, '0, 7'(total_q),
							            total_q == '0, 1'b1};
						end else if (total_q == olps_pkg::CAP_CNT) begin
							strobe <= 1'b1;
							result <= '{olps_pkg::ST_FULL, '0, '0, 7'(total_q),
							            total_q == '0, 1'b1};
						end else begin
							ins_q <= 1'b1;
							value_q <= cmd.value;
							ptr_q <= total_q;
							if (cmd.kind == olps_pkg::K_PUSH_BACK) begin
								slot_q <= total_q;
								state_q <= S_INS_WR;
							end else begin
								slot_q <= (cmd.kind == olps_pkg::K_PUSH_FRONT) ? '0
								        : olps_pkg::CNT_W'(cmd.position - 8'd1);
								// an insert at the end needs no shift
								state_q <= (total_q == '0 ||
								            (cmd.kind == olps_pkg::K_INSERT &&
								             pos9 == tot9 + 9'd1)) ? S_INS_WR : S_SH_RD;
							end
						end
					end else if (cmd.kind == olps_pkg::K_POP_BACK ||
					             cmd.kind == olps_pkg::K_POP_FRONT ||
					             cmd.kind == olps_pkg::K_REMOVE) begin
						if (cmd.kind == olps_pkg::K_REMOVE &&
						    (pos9 == 9'd0 || pos9 > tot9)) begin
							strobe <= 1'b1;
							result <= '{olps_pkg::ST_BADPOS, '0, '0, 7'(total_q),
							            total_q == '0, 1'b1};
						end else if (total_q == '0) begin
							strobe <= 1'b1;
							result <= '{olps_pkg::ST_EMPTY, '0, '0, 7'(total_q),
							            1'b1, 1'b1};
						end else begin
							ins_q <= 1'b0;
							if (cmd.kind == olps_pkg::K_POP_BACK ||
							    (cmd.kind == olps_pkg::K_REMOVE && pos9 == tot9)) begin
								// dropping the tail needs no shift
								total_q <= total_dec;
								strobe <= 1'b1;
								result <= '{olps_pkg::ST_OK, '0, '0, 7'(total_dec),
								            total_dec == '0, 1'b1};
							end else begin
								ptr_q <= (cmd.kind == olps_pkg::K_POP_FRONT) ? '0
								       : olps_pkg::CNT_W'(cmd.position - 8'd1);
								state_q <= S_SH_RD;
							end
						end
					end else if (cmd.kind == olps_pkg::K_READ_FWD ||
					             cmd.kind == olps_pkg::K_READ_BWD ||
					             cmd.kind == olps_pkg::K_FIND_MIN) begin
						if (total_q == '0) begin
							strobe <= 1'b1;
							result <= '{olps_pkg::ST_EMPTY, '0, '0, 7'(total_q),
							            1'b1, 1'b1};
						end else begin
							ptr_q <= '0;
							fwd_q <= cmd.kind != olps_pkg::K_READ_BWD;
							state_q <= (cmd.kind == olps_pkg::K_FIND_MIN) ? S_MIN_RD
							                                              : S_RO_RD;
						end
					end else if (cmd.kind == olps_pkg::K_CLEAR) begin
						total_q <= '0;
						strobe <= 1'b1;
						result <= '{olps_pkg::ST_OK, '0, '0, '0, 1'b1, 1'b1};
					end else begin
						strobe <= 1'b1;
						result <= '{olps_pkg::ST_OK, '0, '0, 7'(total_q),
						            total_q == '0, 1'b1};
					end
				end
				S_SH_RD: state_q <= S_SH_WR;
				S_SH_WR: begin
					if (ins_q) begin
						ptr_q <= ptr_q - olps_pkg::CNT_W'(1);
						state_q <= (ptr_q - olps_pkg::CNT_W'(1) > slot_q) ? S_SH_RD
						                                                 : S_INS_WR;
					end else begin
						ptr_q <= ptr_q + olps_pkg::CNT_W'(1);
						if (ptr_q + olps_pkg::CNT_W'(2) < total_q) begin
							state_q <= S_SH_RD;
						end else begin
							total_q <= total_dec;
							strobe <= 1'b1;
							result <= '{olps_pkg::ST_OK, '0, '0, 7'(total_dec),
							            total_dec == '0, 1'b1};
							state_q <= S_IDLE;
						end
					end
				end
				S_INS_WR: begin
					total_q <= total_inc;
					strobe <= 1'b1;
					result <= '{olps_pkg::ST_OK, '0, '0, 7'(total_inc), 1'b0, 1'b1};
					state_q <= S_IDLE;
				end
				S_RO_RD: state_q <= S_RO_EM;
				S_RO_EM: begin
					strobe <= 1'b1;
					result <= '{olps_pkg::ST_OK, rdata,
					            7'(olps_pkg::CNT_W'(ro_slot + olps_pkg::CNT_W'(1))),
					            7'(total_q), 1'b0, ptr_q == total_dec};
					ptr_q <= ptr_q + olps_pkg::CNT_W'(1);
					state_q <= (ptr_q == total_dec) ? S_IDLE : S_RO_RD;
				end
				S_MIN_RD: state_q <= S_MIN_CM;
				S_MIN_CM: begin
					logic               take;
					logic signed [31:0] bv;
					olps_pkg::cnt_t     bp;
					take = (ptr_q == '0) || (rdata < best_val_q);
					bv = take ? rdata : best_val_q;
					bp = take ? ptr_q : best_q;
					best_val_q <= bv;
					best_q <= bp;
					ptr_q <= ptr_q + olps_pkg::CNT_W'(1);
					if (ptr_q == total_dec) begin
						strobe <= 1'b1;
						result <= '{olps_pkg::ST_OK, bv,
						            7'(olps_pkg::CNT_W'(bp + olps_pkg::CNT_W'(1))),
						            7'(total_q), 1'b0, 1'b1};
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MIN_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: hdl/olps_checker.sv
`timescale 1ns / 1ps
module olps_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input olps_pkg::cmd_t cmd,
	input logic           busy,
	input logic           strobe,
	input olps_pkg::res_t result
);
	// a word that is not the last of a read-out keeps the block busy
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> busy) else $error("busy dropped mid read-out");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != olps_pkg::ST_OK |-> result.last)
		else $error("error status on a non-final word");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> result.list_empty == (result.entry_count == 7'd0))
		else $error("list_empty disagrees with entry_count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status == olps_pkg::ST_FULL |->
		result.entry_count == 7'(olps_pkg::CAPACITY))
		else $error("full reported below capacity");

	// a clear answers at once with an empty list
	a_clear_now: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.kind == olps_pkg::K_CLEAR |=>
		strobe && result.entry_count == 7'd0)
		else $error("clear did not answer with an empty list");
endmodule

bind ordered_list_positional_store olps_checker u_olps_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
	.busy(busy), .strobe(strobe), .result(result)
);

FILE: test/ordered_list_positional_store_tb.sv
`timescale 1ns / 1ps
module ordered_list_positional_store_tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	olps_pkg::cmd_t cmd = '0;
	logic busy;
	logic strobe;
	olps_pkg::res_t result;

	int err_count = 0;
	int gap_pct = 13;

	ordered_list_positional_store u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.strobe(strobe),
		.result(result)
	);

	always #5 clk = ~clk;

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	class list_scoreboard;
		logic signed [31:0] entries[$];
		olps_pkg::res_t pending[$];

		function void push_res(logic [1:0] st, logic signed [31:0] v, int p, logic lst);
			olps_pkg::res_t r;
			r.status = st;
			r.item_value = v;
			r.item_position = 7'(p);
			r.entry_count = 7'(entries.size());
			r.list_empty = entries.size() == 0;
			r.last = lst;
			pending.push_back(r);
		endfunction

		function void note_word(olps_pkg::cmd_t c);
			int n;
			int best;
			n = entries.size();
			case (c.kind)
				olps_pkg::K_PUSH_BACK, olps_pkg::K_PUSH_FRONT: begin
					if (n >= olps_pkg::CAPACITY) begin
						push_res(olps_pkg::ST_FULL, 0, 0, 1);
					end else begin
						if (c.kind == olps_pkg::K_PUSH_BACK) entries.push_back(c.value);
						else entries.push_front(c.value);
						push_res(olps_pkg::ST_OK, 0, 0, 1);
					end
				end
				olps_pkg::K_INSERT: begin
					if (c.position < 1 || c.position > n + 1) begin
						push_res(olps_pkg::ST_BADPOS, 0, 0, 1);
					end else if (n >= olps_pkg::CAPACITY) begin
						push_res(olps_pkg::ST_FULL, 0, 0, 1);
					end else begin
						entries.insert(c.position - 1, c.value);
						push_res(olps_pkg::ST_OK, 0, 0, 1);
					end
				end
				olps_pkg::K_POP_BACK, olps_pkg::K_POP_FRONT: begin
					if (n == 0) begin
						push_res(olps_pkg::ST_EMPTY, 0, 0, 1);
					end else begin
						if (c.kind == olps_pkg::K_POP_BACK) void'(entries.pop_back());
						else void'(entries.pop_front());
						push_res(olps_pkg::ST_OK, 0, 0, 1);
					end
				end
				olps_pkg::K_REMOVE: begin
					if (c.position < 1 || c.position > n) begin
						push_res(olps_pkg::ST_BADPOS, 0, 0, 1);
					end else begin
						entries.delete(c.position - 1);
						push_res(olps_pkg::ST_OK, 0, 0, 1);
					end
				end
				olps_pkg::K_READ_FWD, olps_pkg::K_READ_BWD: begin
					if (n == 0) push_res(olps_pkg::ST_EMPTY, 0, 0, 1);
					for (int i = 0; i < n; i++) begin
						int s;
						s = (c.kind == olps_pkg::K_READ_FWD) ? i : n - 1 - i;
						push_res(olps_pkg::ST_OK, entries[s], s + 1, i == n - 1);
					end
				end
				olps_pkg::K_FIND_MIN: begin
					if (n == 0) begin
						push_res(olps_pkg::ST_EMPTY, 0, 0, 1);
					end else begin
						best = 0;
						for (int i = 1; i < n; i++)
							if (entries[i] < entries[best]) best = i;
						push_res(olps_pkg::ST_OK, entries[best], best + 1, 1);
					end
				end
				olps_pkg::K_CLEAR: begin
					entries.delete();
					push_res(olps_pkg::ST_OK, 0, 0, 1);
				end
				default: push_res(olps_pkg::ST_OK, 0, 0, 1);
			endcase
		endfunction

		task check_word(olps_pkg::res_t got);
			olps_pkg::res_t want;
			if (pending.size() == 0) begin
				report("result with nothing expected");
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d want %0d", got.status, want.status));
			if (got.item_value !== want.item_value)
				report($sformatf("value %0d want %0d", got.item_value, want.item_value));
			if (got.item_position !== want.item_position)
				report($sformatf("position %0d want %0d", got.item_position,
					want.item_position));
			if (got.entry_count !== want.entry_count)
				report($sformatf("count %0d want %0d", got.entry_count, want.entry_count));
			if (got.list_empty !== want.list_empty)
				report($sformatf("empty %0b want %0b", got.list_empty, want.list_empty));
			if (got.last !== want.last)
				report($sformatf("last %0b want %0b", got.last, want.last));
		endtask
	endclass

	list_scoreboard list_sb = new();

	always @(posedge clk) begin
		if (arst_n && strobe) list_sb.check_word(result);
	end

	// hold start until the word is taken, then drop it unless another follows
	task automatic send_word(input logic [3:0] k, input logic signed [31:0] v,
			input logic [7:0] p);
		olps_pkg::cmd_t c;
		c.kind = k;
		c.value = v;
		c.position = p;
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		list_sb.note_word(c);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (list_sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return $signed(32'($urandom_range(7)));
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic random_word();
		int n;
		logic [3:0] k;
		logic [7:0] p;
		n = list_sb.entries.size();
		k = 4'($urandom_range(15));
		if (k > olps_pkg::K_QUERY && $urandom_range(3) != 0) k = 4'($urandom_range(2));
		// mostly sensible positions, some wild ones
		if ($urandom_range(4) == 0) p = 8'($urandom);
		else p = 8'($urandom_range(n + 1));
		send_word(k, rand_value(), p);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_word(olps_pkg::K_POP_BACK, 0, 0);
		send_word(olps_pkg::K_POP_FRONT, 0, 0);
		send_word(olps_pkg::K_REMOVE, 0, 1);
		send_word(olps_pkg::K_READ_FWD, 0, 0);
		send_word(olps_pkg::K_READ_BWD, 0, 0);
		send_word(olps_pkg::K_FIND_MIN, 0, 0);
		send_word(olps_pkg::K_QUERY, 0, 0);
		send_word(olps_pkg::K_INSERT, 5, 0);
		send_word(olps_pkg::K_INSERT, 5, 2);
		send_word(olps_pkg::K_PUSH_BACK, 32'sh7fff_ffff, 0);
		send_word(olps_pkg::K_PUSH_FRONT, 32'sh8000_0000, 0);
		send_word(olps_pkg::K_INSERT, -3, 2);
		send_word(olps_pkg::K_PUSH_BACK, 32'sh8000_0000, 0);
		send_word(olps_pkg::K_FIND_MIN, 0, 0);
		send_word(olps_pkg::K_REMOVE, 0, 255);
		send_word(4'hF, 32'sh5555_aaaa, 8'haa);
		// fill the list, then overflow both ways
		while (list_sb.entries.size() < olps_pkg::CAPACITY)
			send_word(olps_pkg::K_PUSH_BACK, $signed($urandom), 0);
		send_word(olps_pkg::K_PUSH_FRONT, 1, 0);
		send_word(olps_pkg::K_INSERT, 1, 3);
		send_word(olps_pkg::K_INSERT, 1, 8'(olps_pkg::CAPACITY + 2));
		send_word(olps_pkg::K_READ_BWD, 0, 0);
		send_word(olps_pkg::K_REMOVE, 0, 8'(olps_pkg::CAPACITY));
		send_word(olps_pkg::K_CLEAR, 0, 0);
		drain();
		for (int i = 0; i < 75; i++) begin
			if (i == 25) gap_pct = 56;
			if (i == 50) gap_pct = 0;
			if (i == 40) drain();
			random_word();
		end
		drain();
		if (err_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end
endmodule

FILE: filelist.f
hdl/olps_pkg.sv
hdl/olps_store.sv
hdl/ordered_list_positional_store.sv
hdl/olps_checker.sv
test/ordered_list_positional_store_tb.sv
